// ----- rtl/tcw_pkg.sv -----
package tcw_pkg;

   localparam int COLUMNS_DEFAULT = 80;
   localparam int ROWS_DEFAULT    = 25;
   localparam int QUEUE_DEPTH     = 2;

   localparam int CHAR_W     = 8;
   localparam int IDX_W      = 11;
   localparam int CELL_W     = 16;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 32;

   localparam logic [CHAR_W-1:0] COLOR_RESET  = 8'hF0;
   localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
   localparam logic [CELL_W-1:0] FILL_CELL    = 16'h0063;

   typedef enum logic {
      KIND_WRITE = 1'b0,
      KIND_READ  = 1'b1
   } kind_type;

   typedef struct packed {
      logic              is_read;
      logic              is_newline;
      logic              in_range;
      logic [CHAR_W-1:0] char_code;
      logic [IDX_W-1:0]  cell_index;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_SCROLL,
      ST_FILL,
      ST_EXEC
   } back_state_type;

endpackage

// ----- rtl/text_console_writer.sv -----
// channel | dir | tdata (low bit up)                          | tuser
// req     | in  | char_code[7:0], cell_index[18:8], zero pad  | kind (1 = read)
// rsp     | out | cursor_position[10:0], cell_data[26:11], pad| -
// csr     | in  | csr_wr_en / csr_wr_data = text_color        | -
//
// Write item: done in ST_IDLE; in-range read item: via ST_READ (registered cell store read).
// A write at end of screen scrolls first, through ST_SCROLL and ST_FILL before ST_EXEC
// (one cell copied per cycle over the single store write port, then the bottom row filled).
// Reset: synchronous; a clearing pass zeroes every cell of the store,
// req_tready stays low meanwhile. A 2-entry queue decouples req from the back end,
// so up to two more req transfers are taken while a result waits on rsp_tready.
module text_console_writer #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [tcw_pkg::REQ_DATA_W-1:0] req_tdata,  // char_code, cell_index
   input  logic                           req_tuser,  // kind
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [tcw_pkg::RSP_DATA_W-1:0] rsp_tdata,  // cursor_position, cell_data
   input  logic                           csr_wr_en,
   input  logic [tcw_pkg::CHAR_W-1:0]     csr_wr_data
);
   import tcw_pkg::*;

   logic              clearing;
   logic              q_full, q_push, q_pop, q_valid;
   cmd_type           q_push_data, q_data;
   logic [IDX_W-1:0]  rsp_cursor;
   logic [CELL_W-1:0] rsp_cell;

   tcw_front #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .clearing   (clearing),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_push_data(q_push_data)
   );

   tcw_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data(q_push_data),
      .full     (q_full),
      .pop      (q_pop),
      .valid    (q_valid),
      .pop_data (q_data)
   );

   tcw_back #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .q_valid    (q_valid),
      .q_data     (q_data),
      .q_pop      (q_pop),
      .clearing   (clearing),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_cursor (rsp_cursor),
      .rsp_cell   (rsp_cell)
   );

   assign rsp_tdata = {{(RSP_DATA_W - IDX_W - CELL_W){1'b0}}, rsp_cell, rsp_cursor};

endmodule

// ----- rtl/tcw_front.sv -----
module tcw_front #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [tcw_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                          req_tuser,
   input  logic                          clearing,
   input  logic                          q_full,
   output logic                          q_push,
   output tcw_pkg::cmd_type              q_push_data
);
   import tcw_pkg::*;

   localparam int CELLS = COLUMNS * ROWS;

   logic [CHAR_W-1:0] char_code;
   logic [IDX_W-1:0]  cell_index;

   assign char_code  = req_tdata[CHAR_W-1:0];
   assign cell_index = req_tdata[CHAR_W +: IDX_W];

   assign req_tready = !clearing && !q_full;
   assign q_push     = req_tvalid && req_tready;

   always_comb begin
      q_push_data.is_read    = (kind_type'(req_tuser) == KIND_READ);
      q_push_data.is_newline = (char_code == NEWLINE_CODE);
      q_push_data.in_range   = (32'(cell_index) < 32'(CELLS));
      q_push_data.char_code  = char_code;
      q_push_data.cell_index = cell_index;
   end

endmodule

// ----- rtl/tcw_queue.sv -----
module tcw_queue #(
   parameter int DEPTH = tcw_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tcw_pkg::cmd_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             valid,
   output tcw_pkg::cmd_type pop_data
);
   import tcw_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign valid    = (count_ff != '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/tcw_back.sv -----
module tcw_back #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [tcw_pkg::CHAR_W-1:0]  csr_wr_data,
   input  logic                        q_valid,
   input  tcw_pkg::cmd_type            q_data,
   output logic                        q_pop,
   output logic                        clearing,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [tcw_pkg::IDX_W-1:0]   rsp_cursor,
   output logic [tcw_pkg::CELL_W-1:0]  rsp_cell
);
   import tcw_pkg::*;

   localparam int CELLS  = COLUMNS * ROWS;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int POS_W  = $clog2(CELLS + 1);
   localparam int COL_W  = $clog2(COLUMNS);

   back_state_type     state_ff, state_in;
   logic [POS_W-1:0]   cnt_ff, cnt_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [CHAR_W-1:0]  color_ff;
   cmd_type            cmd_ff, cmd_in;
   logic [CELL_W-1:0]  rd_data_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]   rsp_cursor_ff, rsp_cursor_in;
   logic [CELL_W-1:0]  rsp_cell_ff, rsp_cell_in;

   logic [CELL_W-1:0]  mem [CELLS];
   logic               mem_we, mem_re;
   logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
   logic [CELL_W-1:0]  mem_wdata;

   logic               slot_free, start, at_end, cnt_last;
   cmd_type            exec_cmd;
   logic [POS_W-1:0]   exec_pos;
   logic [COL_W-1:0]   exec_col;
   logic [POS_W-1:0]   src_minus_row;

   assign slot_free     = !rsp_valid_ff || rsp_tready;
   assign start         = q_valid && slot_free;
   assign at_end        = (pos_ff == POS_W'(CELLS));
   assign cnt_last      = (cnt_ff == POS_W'(CELLS - 1));
   assign exec_cmd      = (state_ff == ST_EXEC) ? cmd_ff : q_data;
   assign src_minus_row = cnt_ff - POS_W'(COLUMNS);
   assign clearing      = (state_ff == ST_CLEAR);

   // cursor after a write item
   always_comb begin
      if (exec_cmd.is_newline) begin
         exec_pos = pos_ff + (POS_W'(COLUMNS) - POS_W'(col_ff));
         exec_col = '0;
      end else begin
         exec_pos = pos_ff + POS_W'(1);
         exec_col = (col_ff == COL_W'(COLUMNS - 1)) ? '0 : col_ff + COL_W'(1);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (cnt_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               if (q_data.is_read) begin
                  if (q_data.in_range) state_in = ST_READ;
               end else if (at_end) begin
                  state_in = ST_SCROLL;
               end
            end
         end
         ST_READ: state_in = ST_IDLE;
         ST_SCROLL: begin
            if (cnt_last) state_in = ST_FILL;
         end
         ST_FILL: begin
            if (cnt_last) state_in = ST_EXEC;
         end
         ST_EXEC: state_in = ST_IDLE;
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      q_pop         = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = cnt_ff[ADDR_W-1:0];
      mem_wdata     = '0;
      mem_re        = 1'b0;
      mem_raddr     = cnt_ff[ADDR_W-1:0];
      cnt_in        = cnt_ff;
      pos_in        = pos_ff;
      col_in        = col_ff;
      cmd_in        = cmd_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_cursor_in = rsp_cursor_ff;
      rsp_cell_in   = rsp_cell_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            cnt_in = cnt_ff + POS_W'(1);
         end
         ST_IDLE: begin
            if (start) begin
               q_pop = 1'b1;
               if (q_data.is_read) begin
                  if (q_data.in_range) begin
                     mem_re    = 1'b1;
                     mem_raddr = ADDR_W'(q_data.cell_index);
                  end else begin
                     rsp_valid_in  = 1'b1;
                     rsp_cursor_in = IDX_W'(pos_ff);
                     rsp_cell_in   = '0;
                  end
               end else if (at_end) begin
                  cmd_in    = q_data;
                  mem_re    = 1'b1;
                  mem_raddr = ADDR_W'(COLUMNS);
                  cnt_in    = POS_W'(COLUMNS);
               end else begin
                  mem_we        = !exec_cmd.is_newline;
                  mem_waddr     = pos_ff[ADDR_W-1:0];
                  mem_wdata     = {color_ff, exec_cmd.char_code};
                  pos_in        = exec_pos;
                  col_in        = exec_col;
                  rsp_valid_in  = 1'b1;
                  rsp_cursor_in = IDX_W'(exec_pos);
                  rsp_cell_in   = '0;
               end
            end
         end
         ST_READ: begin
            rsp_valid_in  = 1'b1;
            rsp_cursor_in = IDX_W'(pos_ff);
            rsp_cell_in   = rd_data_ff;
         end
         ST_SCROLL: begin
            // read one ahead, write the row above
            mem_we    = 1'b1;
            mem_waddr = src_minus_row[ADDR_W-1:0];
            mem_wdata = rd_data_ff;
            if (cnt_last) begin
               cnt_in = POS_W'(CELLS - COLUMNS);
            end else begin
               mem_re    = 1'b1;
               mem_raddr = ADDR_W'(cnt_ff + POS_W'(1));
               cnt_in    = cnt_ff + POS_W'(1);
            end
         end
         ST_FILL: begin
            mem_we    = 1'b1;
            mem_wdata = FILL_CELL;
            cnt_in    = cnt_ff + POS_W'(1);
            if (cnt_last) pos_in = POS_W'(CELLS - COLUMNS);
         end
         ST_EXEC: begin
            mem_we        = !exec_cmd.is_newline;
            mem_waddr     = pos_ff[ADDR_W-1:0];
            mem_wdata     = {color_ff, exec_cmd.char_code};
            pos_in        = exec_pos;
            col_in        = exec_col;
            rsp_valid_in  = 1'b1;
            rsp_cursor_in = IDX_W'(exec_pos);
            rsp_cell_in   = '0;
         end
         default: begin
            cnt_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         pos_ff       <= '0;
         col_ff       <= '0;
         color_ff     <= COLOR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pos_ff       <= pos_in;
         col_ff       <= col_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) color_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      rsp_cursor_ff <= rsp_cursor_in;
      rsp_cell_ff   <= rsp_cell_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
   end

   always_ff @(posedge clock) begin
      if (mem_re) rd_data_ff <= mem[mem_raddr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_cursor = rsp_cursor_ff;
   assign rsp_cell   = rsp_cell_ff;

endmodule

// ----- rtl/tcw_checker.sv -----
module tcw_checker #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [tcw_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import tcw_pkg::*;

   localparam int CELLS = COLUMNS * ROWS;

   // store clearing pass blocks input right after reset
   a_clear_blocks_req: assert property (@(posedge clock) reset |=> !req_tready)
      else $error("req_tready high right after reset");

   a_no_rsp_after_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high right after reset");

   a_cursor_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (32'(rsp_tdata[IDX_W-1:0]) <= 32'(CELLS)))
      else $error("cursor beyond end of screen");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled rsp transfer changed");

endmodule

bind text_console_writer tcw_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_tcw_checker (.*);
